[hw/rtl/tile_and_bitmap_layer_compositor_defines.svh]
// Assertion macros used by the checker file.
`ifndef TILE_AND_BITMAP_LAYER_COMPOSITOR_DEFINES_SVH
`define TILE_AND_BITMAP_LAYER_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define TBC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is high.
`define TBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tbc_pkg.sv]
`default_nettype none

package tbc_pkg;

  localparam int MAP_SIDE     = 64;
  localparam int SCREEN_SIDE  = 128;
  localparam int TILE_COUNT   = 256;
  localparam int TILE_SIDE    = 8;
  localparam int PALETTE_SIZE = 256;
  localparam int TILE_BIAS    = 192;

  localparam int MAP_CELLS    = MAP_SIDE * MAP_SIDE;
  localparam int LAYER_CELLS  = SCREEN_SIDE * SCREEN_SIDE;
  localparam int BITMAP_CELLS = TILE_COUNT * TILE_SIDE * TILE_SIDE;

  localparam int MAP_PIX_W = $clog2(MAP_SIDE * TILE_SIDE);
  localparam int SUB_W     = $clog2(TILE_SIDE);
  localparam int CELL_W    = $clog2(MAP_CELLS);
  localparam int SCR_W     = $clog2(SCREEN_SIDE);
  localparam int LAYER_AW  = $clog2(LAYER_CELLS);
  localparam int TILE_W    = $clog2(TILE_COUNT);
  localparam int BMP_AW    = $clog2(BITMAP_CELLS);
  localparam int PAL_AW    = $clog2(PALETTE_SIZE);

  localparam int PIX_W      = 8;
  localparam int COLOR_W    = 16;
  localparam int COORD_W    = 7;
  localparam int ADDR_W     = 14;
  localparam int DATA_W     = 16;
  localparam int KIND_W     = 3;
  localparam int FIELDS_W   = 2 * COORD_W + ADDR_W + DATA_W;
  localparam int TDATA_W    = ((FIELDS_W + 7) / 8) * 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = MAP_PIX_W;

  typedef enum logic [KIND_W-1:0] {
    REQ_RENDER  = 3'd0,
    REQ_MAP     = 3'd1,
    REQ_FRONT   = 3'd2,
    REQ_BACK    = 3'd3,
    REQ_BITMAP  = 3'd4,
    REQ_PALETTE = 3'd5
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TILE_X  = 3'd0,
    CFG_TILE_Y  = 3'd1,
    CFG_FRONT_X = 3'd2,
    CFG_FRONT_Y = 3'd3,
    CFG_BACK_X  = 3'd4,
    CFG_BACK_Y  = 3'd5
  } cfg_idx_t;

  // After address generation.
  typedef struct packed {
    req_t                  kind;
    logic [CELL_W-1:0]     map_addr;
    logic [2*SUB_W-1:0]    sub;
    logic [LAYER_AW-1:0]   front_addr;
    logic [LAYER_AW-1:0]   back_addr;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_W-1:0]     wdata;
  } s1_t;

  // After tile map and layer reads.
  typedef struct packed {
    req_t                  kind;
    logic [TILE_W-1:0]     tile;
    logic [2*SUB_W-1:0]    sub;
    logic [PIX_W-1:0]      front_pix;
    logic [PIX_W-1:0]      back_pix;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_W-1:0]     wdata;
  } s2_t;

  // After tile bitmap read.
  typedef struct packed {
    req_t                  kind;
    logic [PIX_W-1:0]      tile_pix;
    logic [PIX_W-1:0]      front_pix;
    logic [PIX_W-1:0]      back_pix;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_W-1:0]     wdata;
  } s3_t;

endpackage

`default_nettype wire

[hw/rtl/tbc_addr.sv]
`default_nettype none

module tbc_addr (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              en,
  input  wire logic                              in_valid,
  input  wire logic [tbc_pkg::KIND_W-1:0]        in_kind,
  input  wire logic [tbc_pkg::TDATA_W-1:0]       in_data,
  input  wire logic                              cfg_valid,
  input  wire logic [tbc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tbc_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                   cfg_ready,
  output logic                                   out_valid,
  output tbc_pkg::s1_t                           out
);

  logic [tbc_pkg::MAP_PIX_W-1:0] tile_x;
  logic [tbc_pkg::MAP_PIX_W-1:0] tile_y;
  logic [tbc_pkg::SCR_W-1:0]     front_x;
  logic [tbc_pkg::SCR_W-1:0]     front_y;
  logic [tbc_pkg::SCR_W-1:0]     back_x;
  logic [tbc_pkg::SCR_W-1:0]     back_y;

  logic [tbc_pkg::COORD_W-1:0]   pix_x;
  logic [tbc_pkg::COORD_W-1:0]   pix_y;
  logic [tbc_pkg::ADDR_W-1:0]    addr;
  logic [tbc_pkg::DATA_W-1:0]    data;
  logic [tbc_pkg::MAP_PIX_W-1:0] tx;
  logic [tbc_pkg::MAP_PIX_W-1:0] ty;
  logic [tbc_pkg::SCR_W-1:0]     fx;
  logic [tbc_pkg::SCR_W-1:0]     fy;
  logic [tbc_pkg::SCR_W-1:0]     bx;
  logic [tbc_pkg::SCR_W-1:0]     by;
  tbc_pkg::req_t                 kind;
  logic                          known;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_x  <= '0;
      tile_y  <= '0;
      front_x <= '0;
      front_y <= '0;
      back_x  <= '0;
      back_y  <= '0;
    end else if (cfg_valid) begin
      unique case (tbc_pkg::cfg_idx_t'(cfg_index))
        tbc_pkg::CFG_TILE_X:  tile_x  <= cfg_data;
        tbc_pkg::CFG_TILE_Y:  tile_y  <= cfg_data;
        tbc_pkg::CFG_FRONT_X: front_x <= cfg_data[tbc_pkg::SCR_W-1:0];
        tbc_pkg::CFG_FRONT_Y: front_y <= cfg_data[tbc_pkg::SCR_W-1:0];
        tbc_pkg::CFG_BACK_X:  back_x  <= cfg_data[tbc_pkg::SCR_W-1:0];
        tbc_pkg::CFG_BACK_Y:  back_y  <= cfg_data[tbc_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  assign pix_x = in_data[tbc_pkg::COORD_W-1:0];
  assign pix_y = in_data[tbc_pkg::COORD_W +: tbc_pkg::COORD_W];
  assign addr  = in_data[2*tbc_pkg::COORD_W +: tbc_pkg::ADDR_W];
  assign data  = in_data[2*tbc_pkg::COORD_W + tbc_pkg::ADDR_W +: tbc_pkg::DATA_W];
  assign kind  = tbc_pkg::req_t'(in_kind);

  // Map side is a power of two: the wrap is the natural carry-out drop.
  assign tx = tile_x + tbc_pkg::MAP_PIX_W'(tbc_pkg::TILE_BIAS)
            + tbc_pkg::MAP_PIX_W'(pix_x);
  assign ty = tile_y + tbc_pkg::MAP_PIX_W'(tbc_pkg::TILE_BIAS)
            + tbc_pkg::MAP_PIX_W'(pix_y);
  assign fx = front_x + tbc_pkg::SCR_W'(pix_x);
  assign fy = front_y + tbc_pkg::SCR_W'(pix_y);
  assign bx = back_x + tbc_pkg::SCR_W'(pix_x);
  assign by = back_y + tbc_pkg::SCR_W'(pix_y);

  always_comb begin
    unique case (kind)
      tbc_pkg::REQ_RENDER, tbc_pkg::REQ_MAP, tbc_pkg::REQ_FRONT,
      tbc_pkg::REQ_BACK, tbc_pkg::REQ_BITMAP, tbc_pkg::REQ_PALETTE: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid && known;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out.kind       <= kind;
      out.map_addr   <= {tx[tbc_pkg::MAP_PIX_W-1:tbc_pkg::SUB_W],
                         ty[tbc_pkg::MAP_PIX_W-1:tbc_pkg::SUB_W]};
      out.sub        <= {ty[tbc_pkg::SUB_W-1:0], tx[tbc_pkg::SUB_W-1:0]};
      out.front_addr <= {fx, fy};
      out.back_addr  <= {bx, by};
      out.waddr      <= addr;
      out.wdata      <= data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tbc_fetch.sv]
`default_nettype none

module tbc_fetch (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  tbc_pkg::s1_t      in,
  output logic              out_valid,
  output tbc_pkg::s2_t      out
);

  logic [tbc_pkg::PIX_W-1:0] tile_map    [tbc_pkg::MAP_CELLS];
  logic [tbc_pkg::PIX_W-1:0] front_layer [tbc_pkg::LAYER_CELLS];
  logic [tbc_pkg::PIX_W-1:0] back_layer  [tbc_pkg::LAYER_CELLS];

  logic [tbc_pkg::PIX_W-1:0]   map_rd;
  logic [tbc_pkg::PIX_W-1:0]   front_rd;
  logic [tbc_pkg::PIX_W-1:0]   back_rd;
  tbc_pkg::req_t               kind;
  logic [2*tbc_pkg::SUB_W-1:0] sub;
  logic [tbc_pkg::ADDR_W-1:0]  waddr;
  logic [tbc_pkg::DATA_W-1:0]  wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind  <= in.kind;
      sub   <= in.sub;
      waddr <= in.waddr;
      wdata <= in.wdata;
    end
  end

  // Writes land in request order with the reads of neighboring renders.
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid && in.kind == tbc_pkg::REQ_MAP) begin
        tile_map[in.waddr[tbc_pkg::CELL_W-1:0]] <= in.wdata[tbc_pkg::PIX_W-1:0];
      end else begin
        map_rd <= tile_map[in.map_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid && in.kind == tbc_pkg::REQ_FRONT) begin
        front_layer[in.waddr[tbc_pkg::LAYER_AW-1:0]] <= in.wdata[tbc_pkg::PIX_W-1:0];
      end else begin
        front_rd <= front_layer[in.front_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid && in.kind == tbc_pkg::REQ_BACK) begin
        back_layer[in.waddr[tbc_pkg::LAYER_AW-1:0]] <= in.wdata[tbc_pkg::PIX_W-1:0];
      end else begin
        back_rd <= back_layer[in.back_addr];
      end
    end
  end

  always_comb begin
    out.kind      = kind;
    out.tile      = map_rd[tbc_pkg::TILE_W-1:0];
    out.sub       = sub;
    out.front_pix = front_rd;
    out.back_pix  = back_rd;
    out.waddr     = waddr;
    out.wdata     = wdata;
  end

endmodule

`default_nettype wire

[hw/rtl/tbc_tile.sv]
`default_nettype none

module tbc_tile (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         en,
  input  wire logic         in_valid,
  input  tbc_pkg::s2_t      in,
  output logic              out_valid,
  output tbc_pkg::s3_t      out
);

  logic [tbc_pkg::PIX_W-1:0] tile_bitmaps [tbc_pkg::BITMAP_CELLS];

  logic [tbc_pkg::PIX_W-1:0]  bmp_rd;
  tbc_pkg::req_t              kind;
  logic [tbc_pkg::PIX_W-1:0]  front_pix;
  logic [tbc_pkg::PIX_W-1:0]  back_pix;
  logic [tbc_pkg::ADDR_W-1:0] waddr;
  logic [tbc_pkg::DATA_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind      <= in.kind;
      front_pix <= in.front_pix;
      back_pix  <= in.back_pix;
      waddr     <= in.waddr;
      wdata     <= in.wdata;
    end
  end

  // 64 bytes per tile, row major inside the tile.
  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid && in.kind == tbc_pkg::REQ_BITMAP) begin
        tile_bitmaps[in.waddr[tbc_pkg::BMP_AW-1:0]] <= in.wdata[tbc_pkg::PIX_W-1:0];
      end else begin
        bmp_rd <= tile_bitmaps[{in.tile, in.sub}];
      end
    end
  end

  always_comb begin
    out.kind      = kind;
    out.tile_pix  = bmp_rd;
    out.front_pix = front_pix;
    out.back_pix  = back_pix;
    out.waddr     = waddr;
    out.wdata     = wdata;
  end

endmodule

`default_nettype wire

[hw/rtl/tbc_pal.sv]
`default_nettype none

module tbc_pal (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  tbc_pkg::s3_t                       in,
  output logic                               out_valid,
  output logic [tbc_pkg::COLOR_W-1:0]        color
);

  logic [tbc_pkg::COLOR_W-1:0] palette [tbc_pkg::PALETTE_SIZE];

  logic [tbc_pkg::PIX_W-1:0] pix;

  // Tile wins unless transparent, then front, then back.
  always_comb begin
    priority if (in.tile_pix != '0) begin
      pix = in.tile_pix;
    end else if (in.front_pix != '0) begin
      pix = in.front_pix;
    end else begin
      pix = in.back_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid && in.kind == tbc_pkg::REQ_RENDER;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_valid && in.kind == tbc_pkg::REQ_PALETTE) begin
        palette[in.waddr[tbc_pkg::PAL_AW-1:0]] <= in.wdata;
      end else begin
        color <= palette[pix[tbc_pkg::PAL_AW-1:0]];
      end
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tile_and_bitmap_layer_compositor.sv]
// Channel   Dir  Carries
// --------  ---  --------------------------------------------------------
// s_*       in   requests: render pixel or write one of the five memories
// m_*       out  one RGB565 color per render request
// cfg_*     in   scroll offset register writes (index 0..5)
//
// One request per clock while back-pressure from m_tready allows. Four
// register stages, in order: address generation, tile map and layer reads,
// tile bitmap read, palette read (the output register, where a color leaves).
// Reset clears the offsets and valid bits only; memory contents are
// undefined until written, so there is no clearing pass.
// Each stage advances when it is empty or the next one advances, so a
// stalled output fills the bubbles before s_tready drops.
`default_nettype none

module tile_and_bitmap_layer_compositor (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // pix_x[6:0], pix_y[13:7], address[27:14], data[43:28], zero pad[47:44]
  input  wire logic [tbc_pkg::TDATA_W-1:0]     s_tdata,
  // req_type[2:0]
  input  wire logic [tbc_pkg::KIND_W-1:0]      s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // color[15:0]
  output logic [tbc_pkg::COLOR_W-1:0]          m_tdata,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  logic         v1, v2, v3, v4;
  logic         en1, en2, en3, en4;
  tbc_pkg::s1_t s1;
  tbc_pkg::s2_t s2;
  tbc_pkg::s3_t s3;

  // Per-stage advance: a stage moves when empty or when its successor moves.
  assign en4 = !v4 || m_tready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign s_tready = en1;
  assign m_tvalid = v4;

  // Stage 1: offsets plus pixel, wrapped to each store's size.
  tbc_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .en        (en1),
    .in_valid  (s_tvalid),
    .in_kind   (s_tuser),
    .in_data   (s_tdata),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_valid (v1),
    .out       (s1)
  );

  // Stage 2: tile map, front and back layer lookups.
  tbc_fetch u_fetch (
    .clk       (clk),
    .rst       (rst),
    .en        (en2),
    .in_valid  (v1),
    .in        (s1),
    .out_valid (v2),
    .out       (s2)
  );

  // Stage 3: tile bitmap lookup.
  tbc_tile u_tile (
    .clk       (clk),
    .rst       (rst),
    .en        (en3),
    .in_valid  (v2),
    .in        (s2),
    .out_valid (v3),
    .out       (s3)
  );

  // Stage 4: layer priority and palette; write requests end here.
  tbc_pal u_pal (
    .clk       (clk),
    .rst       (rst),
    .en        (en4),
    .in_valid  (v3),
    .in        (s3),
    .out_valid (v4),
    .color     (m_tdata)
  );

endmodule

`default_nettype wire

[hw/rtl/tbc_checker.sv]
`default_nettype none
`include "tile_and_bitmap_layer_compositor_defines.svh"

module tbc_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic [tbc_pkg::TDATA_W-1:0]     s_tdata,
  input wire logic [tbc_pkg::KIND_W-1:0]      s_tuser,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [tbc_pkg::COLOR_W-1:0]     m_tdata,
  input wire logic                            cfg_valid,
  input wire logic                            cfg_ready,
  input wire logic [tbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [tbc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `TBC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `TBC_ASSERT_NEXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata), "result changed while stalled")
  `TBC_ASSERT_IMPLY(a_backpressure, clk, rst, !s_tready, m_tvalid && !m_tready, "input stalled with room in the pipe")
  `TBC_ASSERT_IMPLY(a_reset_empty, clk, rst, $fell(rst), !m_tvalid, "result present right after reset")

endmodule

bind tile_and_bitmap_layer_compositor tbc_checker u_checker (.*);

`default_nettype wire

[test/tb_tile_and_bitmap_layer_compositor.sv]
`timescale 1ns / 1ps

module tb_tile_and_bitmap_layer_compositor;
  import tbc_pkg::*;

  // Run shape
  localparam int PHASES       = 8;    // scroll settings after the directed rows
  localparam int PHASE_ITEMS  = 235;  // memory and render requests per setting
  localparam int DRAIN_CYCLES = 12;   // pipeline is four deep; writes leave no trace
  localparam int HOLD_CYCLES  = 300;  // long output stall, forces input backpressure
  localparam int HOLD_AFTER   = 400;  // requests taken before the long stall starts
  localparam int LIMIT_CYCLES = 300000;

  // Request kinds and register indexes the block has no name for
  localparam logic [KIND_W-1:0]    REQ_SPARE_6 = 3'd6;
  localparam logic [KIND_W-1:0]    REQ_SPARE_7 = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  data;
  } request_t;

  // chk set: color is typed in below instead of taken from the predictor
  typedef struct packed {
    request_t            req;
    logic                chk;
    logic [COLOR_W-1:0]  color;
  } row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [TDATA_W-1:0]     s_tdata;
  logic [KIND_W-1:0]      s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [COLOR_W-1:0]     m_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  tile_and_bitmap_layer_compositor u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the block: scroll registers, the five stores, and a flag
  // per entry telling whether it was ever written. Renders are only sent once
  // every entry on their lookup chain is written.
  // ---------------------------------------------------------------------------
  logic [MAP_PIX_W-1:0] tile_xo, tile_yo;
  logic [SCR_W-1:0]     front_xo, front_yo, back_xo, back_yo;

  logic [PIX_W-1:0]   map_mem   [MAP_CELLS];
  logic [PIX_W-1:0]   bmp_mem   [BITMAP_CELLS];
  logic [PIX_W-1:0]   front_mem [LAYER_CELLS];
  logic [PIX_W-1:0]   back_mem  [LAYER_CELLS];
  logic [COLOR_W-1:0] pal_mem   [PALETTE_SIZE];
  bit map_set   [MAP_CELLS];
  bit bmp_set   [BITMAP_CELLS];
  bit front_set [LAYER_CELLS];
  bit back_set  [LAYER_CELLS];
  bit pal_set   [PALETTE_SIZE];

  logic [COLOR_W-1:0] expected_colors [$];

  int mismatches  = 0;
  int items_sent  = 0;  // memory and render requests taken, spare kinds excluded
  int burst_left  = 0;
  int cycle_count = 0;

  // Tile layer coordinate: scroll plus the fixed bias, wrapping on the map size
  function automatic int unsigned map_coord(int unsigned offs, int unsigned p);
    return (offs + TILE_BIAS + p) % (MAP_SIDE * TILE_SIDE);
  endfunction

  function automatic int unsigned cell_of(int unsigned px, int unsigned py);
    int unsigned tx, ty;
    tx = map_coord(tile_xo, px);
    ty = map_coord(tile_yo, py);
    return (tx / TILE_SIDE) * MAP_SIDE + ty / TILE_SIDE;
  endfunction

  // Pixel within the tile, row major
  function automatic int unsigned sub_of(int unsigned px, int unsigned py);
    int unsigned tx, ty;
    tx = map_coord(tile_xo, px);
    ty = map_coord(tile_yo, py);
    return (ty % TILE_SIDE) * TILE_SIDE + tx % TILE_SIDE;
  endfunction

  function automatic int unsigned bmp_addr_of(int unsigned px, int unsigned py);
    return (map_mem[cell_of(px, py)] % TILE_COUNT) * TILE_SIDE * TILE_SIDE
           + sub_of(px, py);
  endfunction

  // Bitmap layers are column major and wrap on the screen size
  function automatic int unsigned layer_addr(int unsigned ox, int unsigned oy,
                                             int unsigned px, int unsigned py);
    return ((ox + px) % SCREEN_SIDE) * SCREEN_SIDE + (oy + py) % SCREEN_SIDE;
  endfunction

  // Tile pixel first, zero falls through to front, then to back
  function automatic logic [PIX_W-1:0] pick_index(int unsigned px, int unsigned py);
    logic [PIX_W-1:0] p;
    p = bmp_mem[bmp_addr_of(px, py)];
    if (p == 0) p = front_mem[layer_addr(front_xo, front_yo, px, py)];
    if (p == 0) p = back_mem[layer_addr(back_xo, back_yo, px, py)];
    return p;
  endfunction

  function automatic logic [COLOR_W-1:0] compose_color(int unsigned px, int unsigned py);
    return pal_mem[pick_index(px, py) % PALETTE_SIZE];
  endfunction

  // Applies one taken request to the shadow state
  function automatic void apply_request(request_t r, logic typed,
                                        logic [COLOR_W-1:0] typed_color);
    int unsigned a;
    a = r.addr;
    case (r.kind)
      REQ_RENDER:  expected_colors.push_back(typed ? typed_color
                                                   : compose_color(r.px, r.py));
      REQ_MAP: begin
        map_mem[a % MAP_CELLS] = r.data[7:0];
        map_set[a % MAP_CELLS] = 1'b1;
      end
      REQ_FRONT: begin
        front_mem[a % LAYER_CELLS] = r.data[7:0];
        front_set[a % LAYER_CELLS] = 1'b1;
      end
      REQ_BACK: begin
        back_mem[a % LAYER_CELLS] = r.data[7:0];
        back_set[a % LAYER_CELLS] = 1'b1;
      end
      REQ_BITMAP: begin
        bmp_mem[a % BITMAP_CELLS] = r.data[7:0];
        bmp_set[a % BITMAP_CELLS] = 1'b1;
      end
      REQ_PALETTE: begin
        pal_mem[a % PALETTE_SIZE] = r.data;
        pal_set[a % PALETTE_SIZE] = 1'b1;
      end
      default: ;  // spare kinds are dropped
    endcase
  endfunction

  function automatic void set_scroll(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    case (idx)
      CFG_TILE_X:  tile_xo  = v;
      CFG_TILE_Y:  tile_yo  = v;
      CFG_FRONT_X: front_xo = v[SCR_W-1:0];
      CFG_FRONT_Y: front_yo = v[SCR_W-1:0];
      CFG_BACK_X:  back_xo  = v[SCR_W-1:0];
      CFG_BACK_Y:  back_yo  = v[SCR_W-1:0];
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run did not finish within %0d cycles", $time, LIMIT_CYCLES);
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Request side. Bursts of random length, gaps of random length between them,
  // some of zero so that long back-to-back stretches occur.
  // ---------------------------------------------------------------------------
  task automatic send_request(input request_t r, input logic typed = 1'b0,
                              input logic [COLOR_W-1:0] typed_color = '0);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk) s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 64);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= r.kind;
    s_tdata  <= {{(TDATA_W - FIELDS_W){1'b0}}, r.data, r.addr, r.py, r.px};
    while (1) begin
      @(posedge clk);
      if (s_tready) break;
    end
    apply_request(r, typed, typed_color);
    if (r.kind <= REQ_PALETTE) items_sent++;
  endtask

  // Write one store entry; the address carries random wrap bits above the
  // store size, and the upper data byte is noise except for the palette.
  task automatic send_store_write(input logic [KIND_W-1:0] kind, input int unsigned idx,
                                  input logic [PIX_W-1:0] low_byte);
    request_t r;
    int unsigned depth;
    case (kind)
      REQ_MAP:     depth = MAP_CELLS;
      REQ_PALETTE: depth = PALETTE_SIZE;
      default:     depth = LAYER_CELLS;
    endcase
    r.kind = kind;
    r.px   = COORD_W'($urandom_range(0, SCREEN_SIDE - 1));
    r.py   = COORD_W'($urandom_range(0, SCREEN_SIDE - 1));
    r.addr = ADDR_W'(idx + depth * $urandom_range(0, (1 << ADDR_W) / depth - 1));
    r.data = {8'($urandom_range(0, 255)), low_byte};
    send_request(r);
  endtask

  function automatic logic [PIX_W-1:0] maybe_zero_byte();
    return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
  endfunction

  // Fills every unwritten entry that a render of (px, py) would read, in
  // chain order since the tile index picks the bitmap entry.
  task automatic fill_render_chain(input int unsigned px, input int unsigned py);
    int unsigned a;
    a = cell_of(px, py);
    if (!map_set[a]) send_store_write(REQ_MAP, a, 8'($urandom_range(0, 255)));
    a = bmp_addr_of(px, py);
    if (!bmp_set[a]) send_store_write(REQ_BITMAP, a, maybe_zero_byte());
    a = layer_addr(front_xo, front_yo, px, py);
    if (!front_set[a]) send_store_write(REQ_FRONT, a, maybe_zero_byte());
    a = layer_addr(back_xo, back_yo, px, py);
    if (!back_set[a]) send_store_write(REQ_BACK, a, 8'($urandom_range(0, 255)));
    a = pick_index(px, py) % PALETTE_SIZE;
    if (!pal_set[a]) send_store_write(REQ_PALETTE, a, 8'($urandom_range(0, 255)));
  endtask

  function automatic logic [COORD_W-1:0] pick_coord();
    if ($urandom_range(0, 7) == 0)
      return ($urandom_range(0, 1) == 0) ? '0 : COORD_W'(SCREEN_SIDE - 1);
    return COORD_W'($urandom_range(0, SCREEN_SIDE - 1));
  endfunction

  // Half renders with their chain filled, then plain writes anywhere
  // (low byte zero a third of the time to feed the fall-through), some spare kinds.
  task automatic random_step();
    request_t r;
    int sel;
    sel    = $urandom_range(0, 99);
    r.px   = pick_coord();
    r.py   = pick_coord();
    r.addr = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
    r.data = DATA_W'($urandom_range(0, (1 << DATA_W) - 1));
    if (sel < 50) begin
      fill_render_chain(r.px, r.py);
      r.kind = REQ_RENDER;
    end else if (sel < 95) begin
      r.kind = KIND_W'($urandom_range(REQ_MAP, REQ_PALETTE));
      if ($urandom_range(0, 2) == 0) r.data[7:0] = '0;
    end else begin
      r.kind = ($urandom_range(0, 1) == 0) ? REQ_SPARE_6 : REQ_SPARE_7;
    end
    send_request(r);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    while (1) begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    set_scroll(idx, v);
  endtask

  // Nothing pending, and enough cycles for trailing writes to retire
  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows, all at reset scroll. Pixel (0,0) lands on map cell 1560,
  // tile pixel 0, layer entry 0; pixel (127,127) on cell 2535, tile pixel 63,
  // layer entry 16383. Colors are typed in for every render.
  // ---------------------------------------------------------------------------
  row_t directed_rows [22] = '{
    // all three layers zero -> palette entry 0; map address wraps, upper byte ignored
    '{'{REQ_MAP,      7'd0,   7'd0,   14'd13848, 16'hAB00}, 1'b0, 16'h0000},
    '{'{REQ_BITMAP,   7'd0,   7'd0,   14'd0,     16'hFF00}, 1'b0, 16'h0000},
    '{'{REQ_FRONT,    7'd0,   7'd0,   14'd0,     16'h0000}, 1'b0, 16'h0000},
    '{'{REQ_BACK,     7'd0,   7'd0,   14'd0,     16'h0000}, 1'b0, 16'h0000},
    '{'{REQ_PALETTE,  7'd0,   7'd0,   14'd256,   16'hFFFF}, 1'b0, 16'h0000},
    '{'{REQ_RENDER,   7'd0,   7'd0,   14'h3FFF,  16'hFFFF}, 1'b1, 16'hFFFF},
    // back layer picked
    '{'{REQ_BACK,     7'd127, 7'd127, 14'd0,     16'h00FF}, 1'b0, 16'h0000},
    '{'{REQ_PALETTE,  7'd0,   7'd0,   14'd255,   16'h8001}, 1'b0, 16'h0000},
    '{'{REQ_RENDER,   7'd0,   7'd0,   14'd0,     16'h0000}, 1'b1, 16'h8001},
    // front layer picked; palette address wraps
    '{'{REQ_FRONT,    7'd0,   7'd0,   14'd0,     16'h0180}, 1'b0, 16'h0000},
    '{'{REQ_PALETTE,  7'd0,   7'd0,   14'h3F80,  16'h1234}, 1'b0, 16'h0000},
    '{'{REQ_RENDER,   7'd0,   7'd0,   14'd0,     16'h0000}, 1'b1, 16'h1234},
    // tile pixel picked
    '{'{REQ_BITMAP,   7'd0,   7'd0,   14'd0,     16'h0001}, 1'b0, 16'h0000},
    '{'{REQ_PALETTE,  7'd0,   7'd0,   14'd1,     16'h5A5A}, 1'b0, 16'h0000},
    '{'{REQ_RENDER,   7'd0,   7'd0,   14'd0,     16'h0000}, 1'b1, 16'h5A5A},
    // spare kinds: dropped, no color
    '{'{REQ_SPARE_6,  7'h55,  7'h2A,  14'h2AAA,  16'h5555}, 1'b0, 16'h0000},
    '{'{REQ_SPARE_7,  7'h2A,  7'h55,  14'h1555,  16'hAAAA}, 1'b0, 16'h0000},
    // far corner: tile 255, last bitmap and layer entries, back layer -> entry 1
    '{'{REQ_MAP,      7'd0,   7'd0,   14'd2535,  16'h00FF}, 1'b0, 16'h0000},
    '{'{REQ_BITMAP,   7'd0,   7'd0,   14'h3FFF,  16'h0000}, 1'b0, 16'h0000},
    '{'{REQ_FRONT,    7'd0,   7'd0,   14'h3FFF,  16'h0000}, 1'b0, 16'h0000},
    '{'{REQ_BACK,     7'd0,   7'd0,   14'h3FFF,  16'h0001}, 1'b0, 16'h0000},
    '{'{REQ_RENDER,   7'd127, 7'd127, 14'd0,     16'h0000}, 1'b1, 16'h5A5A}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ph, phase_base;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    tile_xo   = '0;
    tile_yo   = '0;
    front_xo  = '0;
    front_yo  = '0;
    back_xo   = '0;
    back_yo   = '0;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].chk, directed_rows[i].color);

    for (ph = 1; ph <= PHASES; ph++) begin
      wait_idle();
      if (ph == 1) begin
        // top of every range, plus the two unused indexes (ignored)
        write_reg(CFG_TILE_X,  9'd511);
        write_reg(CFG_TILE_Y,  9'd511);
        write_reg(CFG_FRONT_X, 9'd127);
        write_reg(CFG_FRONT_Y, 9'd127);
        write_reg(CFG_BACK_X,  9'd127);
        write_reg(CFG_BACK_Y,  9'd127);
        write_reg(CFG_SPARE_6, 9'h1FF);
        write_reg(CFG_SPARE_7, 9'h155);
      end else if (ph == 2) begin
        write_reg(CFG_TILE_X,  9'd0);
        write_reg(CFG_TILE_Y,  9'd0);
        write_reg(CFG_FRONT_X, 9'd0);
        write_reg(CFG_FRONT_Y, 9'd0);
        write_reg(CFG_BACK_X,  9'd0);
        write_reg(CFG_BACK_Y,  9'd0);
      end else begin
        write_reg(CFG_TILE_X,  CFG_DATA_W'($urandom_range(0, 511)));
        write_reg(CFG_TILE_Y,  CFG_DATA_W'($urandom_range(0, 511)));
        write_reg(CFG_FRONT_X, CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(CFG_FRONT_Y, CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(CFG_BACK_X,  CFG_DATA_W'($urandom_range(0, 127)));
        write_reg(CFG_BACK_Y,  CFG_DATA_W'($urandom_range(0, 127)));
      end
      @(negedge clk) cfg_valid <= 1'b0;
      phase_base = items_sent;
      while (items_sent - phase_base < PHASE_ITEMS) random_step();
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Color side. Stall pattern changes after runs of random length: always ready,
  // coin flip, mostly ready, or three of every five. Once, mid run, a long
  // hold-off lets the pipeline fill and push back on requests.
  // ---------------------------------------------------------------------------
  initial begin
    int mode, run, k;
    bit held;
    held     = 1'b0;
    k        = 0;
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      mode = $urandom_range(0, 3);
      run  = $urandom_range(8, 80);
      repeat (run) begin
        @(negedge clk);
        k++;
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= ($urandom_range(0, 9) != 0);
          default: m_tready <= (k % 5 < 3);
        endcase
      end
      if (!held && items_sent >= HOLD_AFTER) begin
        held = 1'b1;
        @(negedge clk) m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
    end
  end

  // Oldest expected color against every color taken
  always @(posedge clk) begin
    logic [COLOR_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_colors.size() == 0) begin
        mismatches++;
        $display("%0t: color with none expected, expected none, got %h", $time, m_tdata);
      end else begin
        want = expected_colors.pop_front();
        if (m_tdata !== want) begin
          mismatches++;
          $display("%0t: color mismatch, expected %h, got %h", $time, want, m_tdata);
        end
      end
    end
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/tbc_pkg.sv
hw/rtl/tbc_addr.sv
hw/rtl/tbc_fetch.sv
hw/rtl/tbc_tile.sv
hw/rtl/tbc_pal.sv
hw/rtl/tile_and_bitmap_layer_compositor.sv
hw/rtl/tbc_checker.sv
test/tb_tile_and_bitmap_layer_compositor.sv
